// ===== sv/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, register indexes and helper functions of the scanline
// unfilter: beat structs for both channels, the filter classes and Paeth.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ROW_BYTES_W = 12;
  localparam int unsigned PIX_BYTES_W = 4;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned POS_W       = 12;
  // widest line-store index over the parameter range (65536 entries)
  localparam int unsigned IDX_FIELD_W = 16;
  // widest left-neighbor select over the parameter range (8 bytes)
  localparam int unsigned BPP_FIELD_W = 3;

  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 12'd4;
  localparam logic [PIX_BYTES_W-1:0] PIX_BYTES_RST = 4'd1;

  // filter-type byte codes of the stream
  localparam logic [BYTE_W-1:0] TYPE_NONE  = 8'd0;
  localparam logic [BYTE_W-1:0] TYPE_SUB   = 8'd1;
  localparam logic [BYTE_W-1:0] TYPE_UP    = 8'd2;
  localparam logic [BYTE_W-1:0] TYPE_AVG   = 8'd3;
  localparam logic [BYTE_W-1:0] TYPE_PAETH = 8'd4;

  typedef enum logic {
    CFG_ROW_BYTES   = 1'b0,
    CFG_PIXEL_BYTES = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FILT_NONE,
    FILT_SUB,
    FILT_UP,
    FILT_AVG,
    FILT_PAETH
  } filt_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              image_start;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte;
    logic              row_last;
  } out_beat_t;

  // one classified data byte, passed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0]      x;
    filt_e                  filt;
    logic                   first_row;
    logic                   new_row;
    logic                   last;
    logic [BPP_FIELD_W-1:0] bpp_sel;
    logic [IDX_FIELD_W-1:0] idx;
  } op_t;

  // unknown types reconstruct like type none
  function automatic filt_e classify(input logic [BYTE_W-1:0] code);
    filt_e f;
    case (code)
      TYPE_SUB:   f = FILT_SUB;
      TYPE_UP:    f = FILT_UP;
      TYPE_AVG:   f = FILT_AVG;
      TYPE_PAETH: f = FILT_PAETH;
      default:    f = FILT_NONE;
    endcase
    return f;
  endfunction

  function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [BYTE_W-1:0] c);
    logic signed [9:0] p;
    logic signed [9:0] q;
    logic signed [9:0] s;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [BYTE_W-1:0] pick;
    p  = $signed({2'b00, b}) - $signed({2'b00, c});
    q  = $signed({2'b00, a}) - $signed({2'b00, c});
    s  = p + q;
    pa = (p < 0) ? 10'(-p) : 10'(p);
    pb = (q < 0) ? 10'(-q) : 10'(q);
    pc = (s < 0) ? 10'(-s) : 10'(s);
    if (pa <= pb && pa <= pc) begin
      pick = a;
    end else if (pb <= pc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

endpackage

`default_nettype wire

// ===== sv/psu_front.sv =====
// ----------------------------------------------------------------------------
// psu_front
// Input side: tracks the row position, latches the filter type of each row
// and turns every data byte into a self-contained op for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_front #(
  parameter int unsigned MAX_ROW_BYTES   = 2048,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire psu_pkg::in_beat_t                   in_beat_i,
  input  wire logic [psu_pkg::ROW_BYTES_W-1:0]     row_bytes_i,
  input  wire logic [psu_pkg::PIX_BYTES_W-1:0]     pix_bytes_i,
  input  wire logic                                full_i,
  output logic                                     push_o,
  output psu_pkg::op_t                             push_op_o
);

  // wide enough for positions, lengths and MAX_ROW_BYTES itself
  localparam int unsigned CW = 18;

  logic [psu_pkg::POS_W-1:0] pos_q, pos_d;
  psu_pkg::filt_e            filt_q, filt_d;
  logic                      first_q, first_d;

  logic                         fire;
  logic                         is_filter;
  logic [CW-1:0]                len;
  logic [CW-1:0]                idx;
  logic                         last;
  logic [psu_pkg::PIX_BYTES_W-1:0] bpp;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign is_filter  = in_beat_i.image_start || (pos_q == '0);

  always_comb begin
    // clamp row length and pixel size into range
    len = CW'(row_bytes_i);
    if (len == '0) begin
      len = CW'(1);
    end
    if (len > CW'(MAX_ROW_BYTES)) begin
      len = CW'(MAX_ROW_BYTES);
    end
    bpp = pix_bytes_i;
    if (bpp == '0) begin
      bpp = psu_pkg::PIX_BYTES_W'(1);
    end
    if (bpp > psu_pkg::PIX_BYTES_W'(MAX_PIXEL_BYTES)) begin
      bpp = psu_pkg::PIX_BYTES_W'(MAX_PIXEL_BYTES);
    end
    idx = CW'(pos_q) - CW'(1);
    if (idx >= CW'(MAX_ROW_BYTES)) begin
      idx = CW'(MAX_ROW_BYTES - 1);
    end
    last = (idx + CW'(1)) >= len;
  end

  always_comb begin
    pos_d   = pos_q;
    filt_d  = filt_q;
    first_d = first_q;
    if (fire) begin
      if (is_filter) begin
        filt_d = psu_pkg::classify(in_beat_i.data_byte);
        pos_d  = psu_pkg::POS_W'(1);
        if (in_beat_i.image_start) begin
          first_d = 1'b1;
        end
      end else if (last) begin
        pos_d   = '0;
        first_d = 1'b0;
      end else begin
        pos_d = psu_pkg::POS_W'(idx + CW'(2));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      filt_q  <= psu_pkg::FILT_NONE;
      first_q <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      filt_q  <= filt_d;
      first_q <= first_d;
    end
  end

  assign push_o              = fire && !is_filter;
  assign push_op_o.x         = in_beat_i.data_byte;
  assign push_op_o.filt      = filt_q;
  assign push_op_o.first_row = first_q;
  assign push_op_o.new_row   = (pos_q == psu_pkg::POS_W'(1));
  assign push_op_o.last      = last;
  assign push_op_o.bpp_sel   = psu_pkg::BPP_FIELD_W'(bpp - psu_pkg::PIX_BYTES_W'(1));
  assign push_op_o.idx       = psu_pkg::IDX_FIELD_W'(idx);

endmodule

`default_nettype wire

// ===== sv/psu_queue.sv =====
// ----------------------------------------------------------------------------
// psu_queue
// Two-entry op queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire psu_pkg::op_t  push_op_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               head_valid_o,
  output psu_pkg::op_t       head_op_o
);

  localparam int unsigned DEPTH = 2;

  psu_pkg::op_t slot_q [DEPTH];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;

  assign full_o       = (count_q == 2'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_op_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/psu_back.sv =====
// ----------------------------------------------------------------------------
// psu_back
// Reconstruction engine: line-store read, predictor, modulo-256 add,
// line-store write-back and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_back #(
  parameter int unsigned MAX_ROW_BYTES   = 2048,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire psu_pkg::op_t  head_op_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output psu_pkg::out_beat_t out_beat_o
);

  localparam int unsigned IDX_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned BPP_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [7:0] line_mem [MAX_ROW_BYTES];
  logic [7:0] rd_q;
  logic [7:0] byp_q;
  logic       byp_sel_q;

  logic               s1_valid_q;
  psu_pkg::op_t       s1_q;
  logic               out_valid_q;
  psu_pkg::out_beat_t out_q;

  logic [7:0] left_q [MAX_PIXEL_BYTES];
  logic [7:0] ul_q   [MAX_PIXEL_BYTES];
  logic [7:0] left_eff [MAX_PIXEL_BYTES];
  logic [7:0] ul_eff   [MAX_PIXEL_BYTES];

  logic             s1_fire;
  logic             load;
  logic [IDX_W-1:0] raddr, waddr;
  logic [BPP_W-1:0] bsel;
  logic [7:0]       a, b, c, pred, r;
  logic [8:0]       ab_sum;

  assign s1_fire = s1_valid_q && (!out_valid_q || out_ready_i);
  assign load    = head_valid_i && (!s1_valid_q || s1_fire);
  assign pop_o   = load;
  assign raddr   = head_op_i.idx[IDX_W-1:0];
  assign waddr   = s1_q.idx[IDX_W-1:0];
  assign bsel    = s1_q.bpp_sel[BPP_W-1:0];

  // line store: one read, one write per cycle
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem[waddr] <= r;
    end
    if (load) begin
      rd_q <= line_mem[raddr];
    end
  end

  // forward a byte written in the same cycle as its read
  always_ff @(posedge clk_i) begin
    if (load) begin
      byp_sel_q <= s1_fire && (waddr == raddr);
      byp_q     <= r;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
      left_eff[i] = s1_q.new_row ? 8'd0 : left_q[i];
      ul_eff[i]   = s1_q.new_row ? 8'd0 : ul_q[i];
    end
    a      = left_eff[bsel];
    c      = ul_eff[bsel];
    b      = s1_q.first_row ? 8'd0 : (byp_sel_q ? byp_q : rd_q);
    ab_sum = {1'b0, a} + {1'b0, b};
    case (s1_q.filt)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = ab_sum[8:1];
      psu_pkg::FILT_PAETH: pred = psu_pkg::paeth(a, b, c);
      default:             pred = 8'd0;
    endcase
    r = s1_q.x + pred;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i] <= 8'd0;
        ul_q[i]   <= 8'd0;
      end
    end else if (s1_fire) begin
      left_q[0] <= r;
      ul_q[0]   <= b;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i] <= left_eff[i-1];
        ul_q[i]   <= ul_eff[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_q <= head_op_i;
    end
    if (s1_fire) begin
      out_q.pixel_byte <= r;
      out_q.row_last   <= s1_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_fire_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("reconstructed byte did not reach the output register");

  a_last_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_q.last |=> out_q.row_last)
    else $error("row end lost between stage and output");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_q))
    else $error("stalled op left the reconstruction stage");

endmodule

`default_nettype wire

// ===== sv/png_scanline_unfilter_core.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// PNG filter reconstruction (none, sub, up, average, Paeth) on a byte stream.
// ----------------------------------------------------------------------------
// Takes one filtered byte per cycle while the queue is not full and returns
// one reconstructed byte per data byte; the filter-type byte at the head of
// each row is consumed without a result. Sustained rate is one byte per cycle
// while out_ready_i stays high, set by the loop of predictor and modulo-256
// add that feeds each result back as the next left neighbor. On its way to the
// output a data byte passes these steps in order: the front classifies the
// byte and writes it into the two-entry queue when it is accepted, the back
// end loads it and reads the prior row from the line store (one read and one
// write port, with forwarding when a row is one byte long), and the result
// lands in the output register. Input is still taken while a result waits for
// out_ready_i, until the queue fills; once the output drains again, input
// resumes in the cycle after the back end pops an op from the queue.
// The line store needs no clearing: the first row of each image, flagged by
// image_start, reads the prior row as zero. Program row_bytes (index 0) and
// bytes_per_pixel (index 1) only while the block is idle; out-of-range values
// saturate to 1..MAX_ROW_BYTES and 1..MAX_PIXEL_BYTES.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter_core #(
  parameter int unsigned MAX_ROW_BYTES   = 2048,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_idx_i,
  input  wire logic [psu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire psu_pkg::in_beat_t                in_beat_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output psu_pkg::out_beat_t                    out_beat_o
);

  logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_q;
  logic [psu_pkg::PIX_BYTES_W-1:0] pix_bytes_q;

  logic         push;
  psu_pkg::op_t push_op;
  logic         full;
  logic         pop;
  logic         head_valid;
  psu_pkg::op_t head_op;

  // configuration registers; write-only, no wait state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= psu_pkg::ROW_BYTES_RST;
      pix_bytes_q <= psu_pkg::PIX_BYTES_RST;
    end else if (cfg_we_i) begin
      case (psu_pkg::cfg_idx_e'(cfg_idx_i))
        psu_pkg::CFG_ROW_BYTES:   row_bytes_q <= cfg_data_i[psu_pkg::ROW_BYTES_W-1:0];
        psu_pkg::CFG_PIXEL_BYTES: pix_bytes_q <= cfg_data_i[psu_pkg::PIX_BYTES_W-1:0];
        default: begin
          row_bytes_q <= row_bytes_q;
        end
      endcase
    end
  end

  // front: row position tracking and byte classification
  psu_front #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .row_bytes_i(row_bytes_q),
    .pix_bytes_i(pix_bytes_q),
    .full_i     (full),
    .push_o     (push),
    .push_op_o  (push_op)
  );

  // decouple front and back so each side stalls on its own
  psu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_op_i   (push_op),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_op_o   (head_op)
  );

  // back: line store, predictor and output register
  psu_back #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_op_i   (head_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for png_scanline_unfilter_core.
// ----------------------------------------------------------------------------
// Drives filtered scanline streams through the valid/ready input and rebuilds
// every expected pixel byte in a behavioral copy of PNG filter reconstruction
// (none, sub, up, average, Paeth, unknown types). A checker compares each
// output beat field by field with the oldest expected beat. Directed rows
// cover the filter types and byte extremes, then mid-row events, register
// extremes, a long output stall and a long run of random images with random
// idling on both sides.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_MAX      = 2048;
  localparam int unsigned PIX_MAX      = 8;
  // cycles to let a filter-type beat clear the pipeline before a register write
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RAND_BEATS   = 1100;
  localparam logic [psu_pkg::BYTE_W-1:0] TYPE_TOP_UNKNOWN = 8'hff;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic                           cfg_idx_i   = 1'b0;
  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  psu_pkg::in_beat_t              in_beat_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  psu_pkg::out_beat_t             out_beat_o;

  png_scanline_unfilter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  psu_pkg::out_beat_t pixel_expect_q[$];
  int unsigned err_count     = 0;
  int unsigned beats_sent    = 0;
  bit          src_idle_en   = 1'b1;
  bit          sink_stall_en = 1'b1;
  int unsigned sink_hold     = 0;

  // register shadows, updated as each write lands
  logic [psu_pkg::ROW_BYTES_W-1:0] row_len_reg   = psu_pkg::ROW_BYTES_RST;
  logic [psu_pkg::PIX_BYTES_W-1:0] pix_bytes_reg = psu_pkg::PIX_BYTES_RST;

  // behavioral unfilter state
  logic [psu_pkg::BYTE_W-1:0] prior_row    [ROW_MAX];
  logic [psu_pkg::BYTE_W-1:0] left_hist    [PIX_MAX];
  logic [psu_pkg::BYTE_W-1:0] up_left_hist [PIX_MAX];
  int unsigned                row_pos      = 0;  // 0: next beat is a filter-type byte
  logic [psu_pkg::BYTE_W-1:0] row_filter   = '0;
  bit                         first_row_p  = 1'b1;
  int unsigned                written_hi   = 0;  // line-store entries written so far

  // --------------------------------------------------------------------------
  // Reconstruction
  // --------------------------------------------------------------------------
  function automatic int unsigned row_len_eff();
    if (row_len_reg == 0) return 1;
    if (row_len_reg > ROW_MAX) return ROW_MAX;
    return 32'(row_len_reg);
  endfunction

  function automatic logic [psu_pkg::BYTE_W-1:0] paeth_pick(input int a, input int b,
                                                            input int c);
    int da;
    int db;
    int dc;
    da = (b > c) ? b - c : c - b;
    db = (a > c) ? a - c : c - a;
    dc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
    if (da <= db && da <= dc) return 8'(a);
    if (db <= dc) return 8'(b);
    return 8'(c);
  endfunction

  // Advance the reconstruction by one accepted beat; queue the pixel it yields.
  function automatic void unfilter_predict(input psu_pkg::in_beat_t beat);
    int unsigned                bpp;
    int unsigned                idx;
    int unsigned                i;
    logic [psu_pkg::BYTE_W-1:0] a;
    logic [psu_pkg::BYTE_W-1:0] b;
    logic [psu_pkg::BYTE_W-1:0] c;
    logic [psu_pkg::BYTE_W-1:0] pred;
    psu_pkg::out_beat_t         res;
    // filter-type byte: open a row, clear both neighbor histories
    if (beat.image_start || row_pos == 0) begin
      if (beat.image_start) first_row_p = 1'b1;
      row_filter = beat.data_byte;
      for (i = 0; i < PIX_MAX; i++) begin
        left_hist[i]    = '0;
        up_left_hist[i] = '0;
      end
      row_pos = 1;
      return;
    end
    bpp = (pix_bytes_reg == 0) ? 1 :
          ((pix_bytes_reg > PIX_MAX) ? PIX_MAX : 32'(pix_bytes_reg));
    idx = row_pos - 1;
    if (idx >= ROW_MAX) idx = ROW_MAX - 1;
    a = left_hist[bpp-1];
    c = up_left_hist[bpp-1];
    b = first_row_p ? '0 : prior_row[idx];
    case (row_filter)
      psu_pkg::TYPE_SUB:   pred = a;
      psu_pkg::TYPE_UP:    pred = b;
      psu_pkg::TYPE_AVG:   pred = 8'((int'(a) + int'(b)) >> 1);
      psu_pkg::TYPE_PAETH: pred = paeth_pick(int'(a), int'(b), int'(c));
      default:             pred = '0;
    endcase
    res.pixel_byte = beat.data_byte + pred;
    prior_row[idx] = res.pixel_byte;
    if (idx + 1 > written_hi) written_hi = idx + 1;
    for (i = PIX_MAX - 1; i > 0; i--) begin
      left_hist[i]    = left_hist[i-1];
      up_left_hist[i] = up_left_hist[i-1];
    end
    left_hist[0]    = res.pixel_byte;
    up_left_hist[0] = b;
    res.row_last = (idx + 1 >= row_len_eff());
    if (res.row_last) begin
      row_pos     = 0;
      first_row_p = 1'b0;
    end else begin
      row_pos = idx + 2;
    end
    pixel_expect_q.push_back(res);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers; all of them start and end at a falling edge
  // --------------------------------------------------------------------------
  // mostly back to back, sometimes a short gap, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  function automatic logic [psu_pkg::BYTE_W-1:0] rand_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic logic [psu_pkg::BYTE_W-1:0] pick_filter();
    case ($urandom_range(5))
      0:       return psu_pkg::TYPE_NONE;
      1:       return psu_pkg::TYPE_SUB;
      2:       return psu_pkg::TYPE_UP;
      3:       return psu_pkg::TYPE_AVG;
      4:       return psu_pkg::TYPE_PAETH;
      default: return 8'($urandom_range(255, int'(psu_pkg::TYPE_PAETH) + 1));
    endcase
  endfunction

  // Offer one beat, hold it until accepted, then predict its effect.
  task automatic send_byte(input logic [psu_pkg::BYTE_W-1:0] value, input logic img);
    int unsigned       gap;
    psu_pkg::in_beat_t beat;
    beat.data_byte   = value;
    beat.image_start = img;
    gap = src_idle_en ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    unfilter_predict(beat);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_data(input int unsigned n);
    repeat (n) send_byte(rand_byte(), 1'b0);
  endtask

  // Filter byte plus n data bytes (n < 0: a full row). Force an image start
  // when mid-row, or when the row would read line-store entries never written.
  task automatic send_row(input logic [psu_pkg::BYTE_W-1:0] filt, input logic img,
                          input int n);
    if (row_pos != 0 || (!first_row_p && row_len_eff() > written_hi)) img = 1'b1;
    send_byte(filt, img);
    send_data((n < 0) ? row_len_eff() : 32'(n));
  endtask

  task automatic send_row4(input logic [psu_pkg::BYTE_W-1:0] filt, input logic img,
                           input logic [31:0] px);
    send_byte(filt, img);
    send_byte(px[31:24], 1'b0);
    send_byte(px[23:16], 1'b0);
    send_byte(px[15:8], 1'b0);
    send_byte(px[7:0], 1'b0);
  endtask

  // Drop valid and wait until every expected pixel is back, then let any
  // filter-type beat still in flight settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pixel_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input psu_pkg::cfg_idx_e idx,
                           input logic [psu_pkg::CFG_DATA_W-1:0] value);
    wait_drained();
    // unused upper bits of the pixel-size write carry noise
    if (idx == psu_pkg::CFG_PIXEL_BYTES) begin
      value = {8'($urandom), value[psu_pkg::PIX_BYTES_W-1:0]};
    end
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == psu_pkg::CFG_ROW_BYTES) row_len_reg = value;
    else pix_bytes_reg = value[psu_pkg::PIX_BYTES_W-1:0];
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here on request
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold != 0) begin
        sink_hold--;
        out_ready_i <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (sink_stall_en && $urandom_range(99) < 25) begin
        stall = idle_len();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: each output beat against the oldest expected pixel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    psu_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_expect_q.size() == 0) begin
        $display("%0t ns: unexpected beat, got pixel_byte=%02h row_last=%0b",
                 $time, out_beat_o.pixel_byte, out_beat_o.row_last);
        err_count++;
      end else begin
        want = pixel_expect_q.pop_front();
        if (out_beat_o.pixel_byte !== want.pixel_byte) begin
          $display("%0t ns: pixel_byte expected %02h got %02h",
                   $time, want.pixel_byte, out_beat_o.pixel_byte);
          err_count++;
        end
        if (out_beat_o.row_last !== want.row_last) begin
          $display("%0t ns: row_last expected %0b got %0b",
                   $time, want.row_last, out_beat_o.row_last);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset register values, every filter type, byte extremes and wrap-around.
  // The first row after reset comes without image_start and reads zero above.
  task automatic test_filter_types();
    send_row4(psu_pkg::TYPE_NONE,  1'b0, 32'h00ff807f);
    send_row4(psu_pkg::TYPE_SUB,   1'b0, 32'hff01ff02);
    send_row4(psu_pkg::TYPE_UP,    1'b0, 32'h01ff8000);
    send_row4(psu_pkg::TYPE_AVG,   1'b0, 32'hffff0180);
    send_row4(psu_pkg::TYPE_PAETH, 1'b0, 32'h00ff7f80);
    send_row4(TYPE_TOP_UNKNOWN,    1'b0, 32'h55aa01fe);
    send_row4(psu_pkg::TYPE_PAETH, 1'b1, 32'h10203040);
  endtask

  // Image start inside a row, pixel size and row length changed mid-row.
  task automatic test_mid_row_events();
    write_reg(psu_pkg::CFG_ROW_BYTES, 12'd8);
    write_reg(psu_pkg::CFG_PIXEL_BYTES, 12'd2);
    send_row(psu_pkg::TYPE_PAETH, 1'b1, -1);
    send_row(psu_pkg::TYPE_SUB, 1'b0, 3);
    // abandon the row: no row_last, this byte opens a new image
    send_row(psu_pkg::TYPE_UP, 1'b1, -1);
    send_row(psu_pkg::TYPE_AVG, 1'b0, 2);
    write_reg(psu_pkg::CFG_PIXEL_BYTES, 12'd1);
    send_data(2);
    // shrink below the current position: the next data byte closes the row
    write_reg(psu_pkg::CFG_ROW_BYTES, 12'd3);
    send_data(1);
    send_row(psu_pkg::TYPE_PAETH, 1'b0, -1);
    send_row(psu_pkg::TYPE_SUB, 1'b0, -1);
  endtask

  // Out-of-range and boundary register values; one-byte rows run back to back
  // with no idling on either side.
  task automatic test_config_extremes();
    int unsigned i;
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    write_reg(psu_pkg::CFG_ROW_BYTES, 12'd0);
    write_reg(psu_pkg::CFG_PIXEL_BYTES, 12'd0);
    for (i = 0; i < 12; i++) send_row(i[0] ? psu_pkg::TYPE_UP : pick_filter(), i == 0, -1);
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    write_reg(psu_pkg::CFG_ROW_BYTES, 12'd20);
    write_reg(psu_pkg::CFG_PIXEL_BYTES, 12'd15);
    for (i = 0; i < 5; i++) send_row(pick_filter(), 1'b0, -1);
    // widest pixel and the top row-length value; the long row is cut short
    // by the image start of the next test
    write_reg(psu_pkg::CFG_PIXEL_BYTES, 12'd8);
    write_reg(psu_pkg::CFG_ROW_BYTES, 12'hfff);
    send_row(psu_pkg::TYPE_PAETH, 1'b1, 200);
  endtask

  // Long receiver hold-off while the sender keeps offering, so the block
  // fills and stalls its input; then a sender pause until all is back.
  task automatic test_backpressure();
    int unsigned i;
    write_reg(psu_pkg::CFG_ROW_BYTES, 12'd6);
    write_reg(psu_pkg::CFG_PIXEL_BYTES, 12'd3);
    src_idle_en = 1'b0;
    sink_hold   = HOLD_CYCLES;
    for (i = 0; i < 8; i++) send_row(pick_filter(), i == 0, -1);
    src_idle_en = 1'b1;
    send_row(psu_pkg::TYPE_PAETH, 1'b0, 4);
    wait_drained();
    send_data(2);
    for (i = 0; i < 4; i++) send_row(pick_filter(), 1'b0, -1);
  endtask

  // Random images: mostly well-formed rows with random content under random
  // settings, some image starts, unknown types and broken rows.
  task automatic test_random_streams();
    int unsigned base;
    int unsigned pick;
    int unsigned rows;
    int unsigned i;
    logic [psu_pkg::CFG_DATA_W-1:0] len;
    base = beats_sent;
    while (beats_sent - base < RAND_BEATS) begin
      src_idle_en   = ($urandom_range(3) != 0);
      sink_stall_en = ($urandom_range(3) != 0);
      pick = $urandom_range(99);
      if (pick < 70) len = psu_pkg::CFG_DATA_W'($urandom_range(16, 1));
      else if (pick < 88) len = psu_pkg::CFG_DATA_W'($urandom_range(64, 17));
      else if (pick < 94) len = '0;
      else len = psu_pkg::CFG_DATA_W'($urandom_range(300, 65));
      write_reg(psu_pkg::CFG_ROW_BYTES, len);
      if ($urandom_range(99) < 85) begin
        write_reg(psu_pkg::CFG_PIXEL_BYTES,
                  psu_pkg::CFG_DATA_W'($urandom_range(PIX_MAX, 1)));
      end else begin
        write_reg(psu_pkg::CFG_PIXEL_BYTES,
                  $urandom_range(1) ? '0 :
                  psu_pkg::CFG_DATA_W'($urandom_range(15, PIX_MAX + 1)));
      end
      rows = (len > 64) ? 2 : $urandom_range(12, 3);
      for (i = 0; i < rows; i++) begin
        pick = $urandom_range(99);
        if (pick < 94) send_row(pick_filter(), pick < 8, -1);
        else send_row(pick_filter(), pick < 97, int'($urandom_range(row_len_eff() - 1, 0)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_filter_types();
    test_mid_row_events();
    test_config_extremes();
    test_backpressure();
    test_random_streams();
    wait_drained();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard stop if the stream or the results hang
  initial begin
    #5_000_000;
    $display("%0t ns: timeout, %0d pixels still expected", $time, pixel_expect_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
sv/psu_pkg.sv
sv/psu_front.sv
sv/psu_queue.sv
sv/psu_back.sv
sv/png_scanline_unfilter_core.sv
tb/tb_top.sv
